@@ design/quaternion_rotate_vector3_top_macros.svh @@
// Assertion macros for the quaternion vector rotation block.
// Used by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef QUATERNION_ROTATE_VECTOR3_TOP_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR3_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define QRV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qrv check failed: same-cycle implication");

// Next-cycle implication, sampled on i_clk, off during reset.
`define QRV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qrv check failed: next-cycle implication");

`endif

@@ design/qrv_pkg.sv @@
// Shared constants, types and width helpers for the quaternion rotation block.
// No dependencies.
`timescale 1ns / 1ps

package qrv_pkg;

    localparam int QUAT_WIDTH    = 16;
    localparam int TGUARD        = 4;
    localparam int VEC_WIDTH_DEF = 16;
    localparam int QUAT_FRAC_DEF = 14;

    localparam int NUM_AXES   = 3;
    localparam int NUM_STAGES = 4;

    // stage indexes
    localparam int STG_MUL1 = 0;
    localparam int STG_T    = 1;
    localparam int STG_MUL2 = 2;
    localparam int STG_OUT  = 3;

    // cross product neighbors: axis i uses (next, prev)
    localparam int AXIS_NEXT [NUM_AXES] = '{1, 2, 0};
    localparam int AXIS_PREV [NUM_AXES] = '{2, 0, 1};

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

    // width of the first sum including rounding headroom
    function automatic int sum_width(input int vw, input int qfb);
        int a;
        int b;
        a = vw + 18;
        b = qfb - TGUARD + 2;
        return (a > b) ? a : b;
    endfunction

    // width of the rounded intermediate t
    function automatic int t_width(input int vw, input int qfb);
        return sum_width(vw, qfb) - (qfb - TGUARD);
    endfunction

    // width of the second cross difference including rounding headroom
    function automatic int crnd_width(input int vw, input int qfb);
        int a;
        int b;
        a = t_width(vw, qfb) + 18;
        b = qfb + TGUARD + 1;
        return (a > b) ? a : b;
    endfunction

endpackage

@@ design/qrv_pipe_ctrl.sv @@
// Valid bits and per-stage load enables for the four-stage rotation pipeline.
// Depends on qrv_pkg and quaternion_rotate_vector3_top_macros.svh.
`timescale 1ns / 1ps
`include "quaternion_rotate_vector3_top_macros.svh"

module qrv_pipe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output qrv_pkg::t_pipe_ctl o_ctl
);
    import qrv_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] w_ready;

    // a stage can take new data when empty or when it moves on this cycle
    always_comb begin
        w_ready[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_ready[k] = !r_vld[k] || w_ready[k+1];
        end
    end

    always_comb begin
        n_vld[0]      = w_ready[0] ? i_valid : r_vld[0];
        o_ctl.load[0] = w_ready[0] && i_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_vld[k]      = w_ready[k] ? r_vld[k-1] : r_vld[k];
            o_ctl.load[k] = w_ready[k] && r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !w_ready[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    `QRV_ASSERT_NOW(a_stall_only_full, o_stall, &r_vld)
    `QRV_ASSERT_NEXT(a_accept_enters, i_valid && !o_stall, r_vld[0])
    `QRV_ASSERT_NEXT(a_drain_empties, o_valid && !i_stall && !r_vld[NUM_STAGES-2], !o_valid)
    `QRV_ASSERT_NOW(a_out_load_src, o_ctl.load[NUM_STAGES-1], r_vld[NUM_STAGES-2])

endmodule

@@ design/qrv_first_cross.sv @@
// Stages one and two: t = cross(q.xyz, v) + w*v, rounded to TGUARD fraction bits.
// Depends on qrv_pkg; enables come from qrv_pipe_ctrl.
`timescale 1ns / 1ps

module qrv_first_cross #(
    parameter  int VEC_WIDTH      = qrv_pkg::VEC_WIDTH_DEF,
    parameter  int QUAT_FRAC_BITS = qrv_pkg::QUAT_FRAC_DEF,
    localparam int T_W            = qrv_pkg::t_width(VEC_WIDTH, QUAT_FRAC_BITS)
) (
    input  logic                                 i_clk,
    input  qrv_pkg::t_pipe_ctl                   i_ctl,
    input  logic signed [VEC_WIDTH-1:0]          i_vec  [qrv_pkg::NUM_AXES],
    input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] i_quat_w,
    input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] i_quat [qrv_pkg::NUM_AXES],
    output logic signed [VEC_WIDTH-1:0]          o_vec  [qrv_pkg::NUM_AXES],
    output logic signed [qrv_pkg::QUAT_WIDTH-1:0] o_quat [qrv_pkg::NUM_AXES],
    output logic signed [T_W-1:0]                o_t    [qrv_pkg::NUM_AXES]
);
    import qrv_pkg::*;

    localparam int P_W    = VEC_WIDTH + QUAT_WIDTH;
    localparam int SR_W   = sum_width(VEC_WIDTH, QUAT_FRAC_BITS);
    localparam int TSHIFT = QUAT_FRAC_BITS - TGUARD;
    localparam logic signed [SR_W-1:0] T_HALF = SR_W'(1) << (TSHIFT - 1);

    logic signed [P_W-1:0]        r_pa   [NUM_AXES];
    logic signed [P_W-1:0]        r_pb   [NUM_AXES];
    logic signed [P_W-1:0]        r_pw   [NUM_AXES];
    logic signed [VEC_WIDTH-1:0]  r_vec1 [NUM_AXES];
    logic signed [QUAT_WIDTH-1:0] r_q1   [NUM_AXES];
    logic signed [SR_W-1:0]       n_sum  [NUM_AXES];
    logic signed [T_W-1:0]        r_t    [NUM_AXES];
    logic signed [VEC_WIDTH-1:0]  r_vec2 [NUM_AXES];
    logic signed [QUAT_WIDTH-1:0] r_q2   [NUM_AXES];

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        localparam int GN = AXIS_NEXT[g];
        localparam int GP = AXIS_PREV[g];

        // products
        always_ff @(posedge i_clk) begin
            if (i_ctl.load[STG_MUL1]) begin
                r_pa[g]   <= P_W'(i_quat[GN]) * P_W'(i_vec[GP]);
                r_pb[g]   <= P_W'(i_quat[GP]) * P_W'(i_vec[GN]);
                r_pw[g]   <= P_W'(i_quat_w) * P_W'(i_vec[g]);
                r_vec1[g] <= i_vec[g];
                r_q1[g]   <= i_quat[g];
            end
        end

        // three-term sum with round-half-up bias
        assign n_sum[g] = SR_W'(r_pa[g]) - SR_W'(r_pb[g]) + SR_W'(r_pw[g]) + T_HALF;

        always_ff @(posedge i_clk) begin
            if (i_ctl.load[STG_T]) begin
                r_t[g]    <= T_W'(n_sum[g] >>> TSHIFT);
                r_vec2[g] <= r_vec1[g];
                r_q2[g]   <= r_q1[g];
            end
        end

        assign o_t[g]    = r_t[g];
        assign o_vec[g]  = r_vec2[g];
        assign o_quat[g] = r_q2[g];
    end

endmodule

@@ design/qrv_second_cross.sv @@
// Stages three and four: v + round(2*cross(q.xyz, t)), saturated, with clip flag.
// Depends on qrv_pkg; takes t from qrv_first_cross.
`timescale 1ns / 1ps

module qrv_second_cross #(
    parameter  int VEC_WIDTH      = qrv_pkg::VEC_WIDTH_DEF,
    parameter  int QUAT_FRAC_BITS = qrv_pkg::QUAT_FRAC_DEF,
    localparam int T_W            = qrv_pkg::t_width(VEC_WIDTH, QUAT_FRAC_BITS)
) (
    input  logic                                 i_clk,
    input  qrv_pkg::t_pipe_ctl                   i_ctl,
    input  logic signed [VEC_WIDTH-1:0]          i_vec  [qrv_pkg::NUM_AXES],
    input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] i_quat [qrv_pkg::NUM_AXES],
    input  logic signed [T_W-1:0]                i_t    [qrv_pkg::NUM_AXES],
    output logic signed [VEC_WIDTH-1:0]          o_rot  [qrv_pkg::NUM_AXES],
    output logic                                 o_clipped
);
    import qrv_pkg::*;

    localparam int CP_W   = T_W + QUAT_WIDTH;
    localparam int CR_W   = crnd_width(VEC_WIDTH, QUAT_FRAC_BITS);
    localparam int RS_W   = CR_W + 1;
    localparam int CSHIFT = QUAT_FRAC_BITS + TGUARD - 1;
    localparam logic signed [CR_W-1:0] C_HALF = CR_W'(1) << (CSHIFT - 1);
    localparam logic signed [RS_W-1:0] V_MAX  = (RS_W'(1) << (VEC_WIDTH - 1)) - RS_W'(1);
    localparam logic signed [RS_W-1:0] V_MIN  = ~V_MAX;

    logic signed [CP_W-1:0]      r_ca   [NUM_AXES];
    logic signed [CP_W-1:0]      r_cb   [NUM_AXES];
    logic signed [VEC_WIDTH-1:0] r_vec3 [NUM_AXES];
    logic signed [CR_W-1:0]      n_c    [NUM_AXES];
    logic signed [CR_W-1:0]      n_d    [NUM_AXES];
    logic signed [RS_W-1:0]      n_r    [NUM_AXES];
    logic                        n_hi   [NUM_AXES];
    logic                        n_lo   [NUM_AXES];
    logic signed [VEC_WIDTH-1:0] n_rot  [NUM_AXES];
    logic signed [VEC_WIDTH-1:0] r_rot  [NUM_AXES];
    logic                        r_clipped;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        localparam int GN = AXIS_NEXT[g];
        localparam int GP = AXIS_PREV[g];

        always_ff @(posedge i_clk) begin
            if (i_ctl.load[STG_MUL2]) begin
                r_ca[g]   <= CP_W'(i_quat[GN]) * CP_W'(i_t[GP]);
                r_cb[g]   <= CP_W'(i_quat[GP]) * CP_W'(i_t[GN]);
                r_vec3[g] <= i_vec[g];
            end
        end

        // doubling is folded into the shift
        assign n_c[g]   = CR_W'(r_ca[g]) - CR_W'(r_cb[g]) + C_HALF;
        assign n_d[g]   = n_c[g] >>> CSHIFT;
        assign n_r[g]   = RS_W'(n_d[g]) + RS_W'(r_vec3[g]);
        assign n_hi[g]  = n_r[g] > V_MAX;
        assign n_lo[g]  = n_r[g] < V_MIN;
        assign n_rot[g] = n_hi[g] ? VEC_WIDTH'(V_MAX)
                        : n_lo[g] ? VEC_WIDTH'(V_MIN)
                        : VEC_WIDTH'(n_r[g]);

        always_ff @(posedge i_clk) begin
            if (i_ctl.load[STG_OUT]) begin
                r_rot[g] <= n_rot[g];
            end
        end

        assign o_rot[g] = r_rot[g];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[STG_OUT]) begin
            r_clipped <= n_hi[0] | n_lo[0] | n_hi[1] | n_lo[1] | n_hi[2] | n_lo[2];
        end
    end

    assign o_clipped = r_clipped;

endmodule

@@ design/quaternion_rotate_vector3_top.sv @@
// Top level of the quaternion vector rotation pipeline.
// Depends on qrv_pkg, qrv_pipe_ctrl, qrv_first_cross and qrv_second_cross.
`timescale 1ns / 1ps

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  input   | in        | i_valid / o_stall   | i_vec_x/y/z, i_quat_w/x/y/z
//  output  | out       | o_valid / i_stall   | o_rot_x/y/z, o_clipped
//
//  One transaction per cycle sustained while i_stall is low; the four registered stages from input
//  transaction to result valid are: product, sum/round, product, round/add/saturate.
//  Each stage holds its own valid bit and refills as soon as the next stage moves,
//  so the input is stalled only when all four stages hold data and the output stalls.
//  Reset (synchronous, active low) clears the valid bits; payload registers are not reset.
//  A stall freezes every full stage with no empty stage after it; no transaction is dropped or duplicated.

module quaternion_rotate_vector3_top #(
    parameter int VEC_WIDTH      = qrv_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qrv_pkg::QUAT_FRAC_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [VEC_WIDTH-1:0]           i_vec_x,
    input  logic signed [VEC_WIDTH-1:0]           i_vec_y,
    input  logic signed [VEC_WIDTH-1:0]           i_vec_z,
    input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] i_quat_w,
    input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] i_quat_x,
    input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] i_quat_y,
    input  logic signed [qrv_pkg::QUAT_WIDTH-1:0] i_quat_z,

    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [VEC_WIDTH-1:0]           o_rot_x,
    output logic signed [VEC_WIDTH-1:0]           o_rot_y,
    output logic signed [VEC_WIDTH-1:0]           o_rot_z,
    output logic                                  o_clipped
);
    import qrv_pkg::*;

    localparam int T_W = t_width(VEC_WIDTH, QUAT_FRAC_BITS);

    t_pipe_ctl w_ctl;

    // axis-indexed views of the input payload (x, y, z)
    logic signed [VEC_WIDTH-1:0]  w_vec_in  [NUM_AXES];
    logic signed [QUAT_WIDTH-1:0] w_quat_in [NUM_AXES];

    // between the two cross product halves
    logic signed [VEC_WIDTH-1:0]  w_vec_mid  [NUM_AXES];
    logic signed [QUAT_WIDTH-1:0] w_quat_mid [NUM_AXES];
    logic signed [T_W-1:0]        w_t        [NUM_AXES];

    logic signed [VEC_WIDTH-1:0]  w_rot [NUM_AXES];

    assign w_vec_in[0]  = i_vec_x;
    assign w_vec_in[1]  = i_vec_y;
    assign w_vec_in[2]  = i_vec_z;
    assign w_quat_in[0] = i_quat_x;
    assign w_quat_in[1] = i_quat_y;
    assign w_quat_in[2] = i_quat_z;

    // valid bits and load enables for all four stages
    qrv_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctl   (w_ctl)
    );

    // t = cross(q.xyz, v) + w*v, kept with TGUARD fraction bits
    qrv_first_cross #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_first (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_vec    (w_vec_in),
        .i_quat_w (i_quat_w),
        .i_quat   (w_quat_in),
        .o_vec    (w_vec_mid),
        .o_quat   (w_quat_mid),
        .o_t      (w_t)
    );

    // v' = sat(v + round(2*cross(q.xyz, t)))
    qrv_second_cross #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_second (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_vec     (w_vec_mid),
        .i_quat    (w_quat_mid),
        .i_t       (w_t),
        .o_rot     (w_rot),
        .o_clipped (o_clipped)
    );

    assign o_rot_x = w_rot[0];
    assign o_rot_y = w_rot[1];
    assign o_rot_z = w_rot[2];

endmodule
